FILE: src/assert_macros.svh
// Assertion macros shared by the Hill cipher RTL.
// Included by the modules that carry concurrent checks; needs nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/hc2_pkg.sv
// Shared types, constants and mod-26 helpers for the 2x2 Hill cipher.
// No dependencies; imported by every hc2 module and the top level.
package hc2_pkg;

  localparam int KeyW      = 5;
  localparam int LetterW   = 5;
  localparam int SettleW   = 3;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW = $clog2(QueueDepth);
  localparam int QueueCntW = $clog2(QueueDepth + 1);

  localparam logic [LetterW-1:0] LetterX = 5'd23;
  localparam logic [6:0]         AsciiA  = 7'd65;
  localparam logic [7:0]         UpperA  = 8'd65;
  localparam logic [7:0]         UpperZ  = 8'd90;
  localparam logic [7:0]         LowerA  = 8'd97;
  localparam logic [7:0]         LowerZ  = 8'd122;
  localparam logic [7:0]         CaseMask = 8'hDF;

  // key pipeline hold-off: settle counter load value after reset or a config write
  localparam logic [SettleW-1:0] SettleCycles = 3'd4;

  typedef enum logic [2:0] {
    REG_KEY_TL  = 3'd0,
    REG_KEY_TR  = 3'd1,
    REG_KEY_BL  = 3'd2,
    REG_KEY_BR  = 3'd3,
    REG_DECRYPT = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STATUS_OK             = 2'd0,
    STATUS_NOT_INVERTIBLE = 2'd1,
    STATUS_ODD_LENGTH     = 2'd2
  } status_t;

  // one queued unit of work from the front end
  typedef struct packed {
    logic               pair;  // a full letter pair was completed
    logic               odd;   // a single letter is left open at end of message
    logic               eom;
    logic [LetterW-1:0] p1;
    logic [LetterW-1:0] p2;
  } job_t;

  // active matrix as seen by the back end
  typedef struct packed {
    logic               settled;
    logic               ok;
    logic               decrypt;
    logic [LetterW-1:0] m0;
    logic [LetterW-1:0] m1;
    logic [LetterW-1:0] m2;
    logic [LetterW-1:0] m3;
  } mat_t;

  // x mod 26 for x < 1664 (product stays in 19 bits): reciprocal estimate is
  // q or q-1, one fix-up step
  function automatic logic [LetterW-1:0] mod26(input logic [10:0] x);
    logic [18:0] prod;
    logic [5:0]  q;
    logic [10:0] r;
    prod = 19'(x) * 19'd315;
    q    = prod[18:13];
    r    = x - 11'(q) * 11'd26;
    if (r >= 11'd26) r = r - 11'd26;
    return r[LetterW-1:0];
  endfunction

  function automatic logic [LetterW-1:0] red26(input logic [KeyW-1:0] v);
    return (v >= 5'd26) ? v - 5'd26 : v;
  endfunction

  function automatic logic [LetterW-1:0] neg26(input logic [LetterW-1:0] v);
    return (v == 5'd0) ? 5'd0 : 5'd26 - v;
  endfunction

  // multiplicative inverse mod 26, zero where none exists
  function automatic logic [LetterW-1:0] inv26(input logic [LetterW-1:0] v);
    logic [LetterW-1:0] r;
    case (v)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: src/hc2_key.sv
// Key registers and the four-stage pipeline that forms the active matrix.
// Depends on hc2_pkg.
module hc2_key (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [hc2_pkg::KeyW-1:0]  cfg_data,
  output hc2_pkg::mat_t             mat
);
  import hc2_pkg::*;

  logic [KeyW-1:0] key_tl, key_tr, key_bl, key_br;
  logic            decrypt;
  logic [SettleW-1:0] settle;

  // stage 1: reduced key, determinant products
  logic [LetterW-1:0] a1, b1, c1, d1;
  logic [9:0]         ad1, bc1;
  logic               mode1;
  // stage 2: determinant inverse
  logic [LetterW-1:0] a2, b2, c2, d2, di2;
  logic               mode2;
  // stage 3: adjugate products
  logic [LetterW-1:0] a3, b3, c3, d3;
  logic [9:0]         p0, p1, p2, p3;
  logic               ok3, mode3;
  // stage 4: matrix
  logic [LetterW-1:0] m0, m1, m2, m3;
  logic               ok4, mode4;

  logic [LetterW-1:0] ar, br, cr, dr;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_tl  <= 5'd1;
      key_tr  <= 5'd0;
      key_bl  <= 5'd0;
      key_br  <= 5'd1;
      decrypt <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_TL:  key_tl  <= cfg_data;
        REG_KEY_TR:  key_tr  <= cfg_data;
        REG_KEY_BL:  key_bl  <= cfg_data;
        REG_KEY_BR:  key_br  <= cfg_data;
        REG_DECRYPT: decrypt <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // hold-off after reset and after any write until stage 4 is current
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      settle <= SettleCycles;
    end else if (settle != '0) begin
      settle <= settle - 1'b1;
    end
  end

  assign ar = red26(key_tl);
  assign br = red26(key_tr);
  assign cr = red26(key_bl);
  assign dr = red26(key_br);

  always_ff @(posedge clk) begin
    a1    <= ar;
    b1    <= br;
    c1    <= cr;
    d1    <= dr;
    ad1   <= 10'(ar) * 10'(dr);
    bc1   <= 10'(br) * 10'(cr);
    mode1 <= decrypt;

    a2    <= a1;
    b2    <= b1;
    c2    <= c1;
    d2    <= d1;
    di2   <= inv26(mod26(11'(ad1) + 11'd676 - 11'(bc1)));
    mode2 <= mode1;

    a3    <= a2;
    b3    <= b2;
    c3    <= c2;
    d3    <= d2;
    p0    <= 10'(d2) * 10'(di2);
    p1    <= 10'(neg26(b2)) * 10'(di2);
    p2    <= 10'(neg26(c2)) * 10'(di2);
    p3    <= 10'(a2) * 10'(di2);
    ok3   <= (di2 != 5'd0);
    mode3 <= mode2;

    m0    <= mode3 ? mod26(11'(p0)) : a3;
    m1    <= mode3 ? mod26(11'(p1)) : b3;
    m2    <= mode3 ? mod26(11'(p2)) : c3;
    m3    <= mode3 ? mod26(11'(p3)) : d3;
    ok4   <= ok3;
    mode4 <= mode3;
  end

  always_comb begin
    mat.settled = (settle == '0);
    mat.ok      = ok4;
    mat.decrypt = mode4;
    mat.m0      = m0;
    mat.m1      = m1;
    mat.m2      = m2;
    mat.m3      = m3;
  end

endmodule

FILE: src/hc2_front.sv
// Front end: takes bytes, folds case, pairs letters and queues jobs.
// Depends on hc2_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hc2_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,
  input  logic          s_tlast,
  input  logic          q_full,
  output logic          push,
  output hc2_pkg::job_t job
);
  import hc2_pkg::*;

  logic [LetterW-1:0] held, held_next;
  logic               half, half_next;
  logic               acc, is_letter, opens, completes;
  logic [7:0]         upper, idx8;
  logic [LetterW-1:0] idx;

  assign s_tready  = !q_full;
  assign acc       = s_tvalid && s_tready;
  assign is_letter = (s_tdata >= UpperA && s_tdata <= UpperZ) ||
                     (s_tdata >= LowerA && s_tdata <= LowerZ);
  assign upper     = s_tdata & CaseMask;
  assign idx8      = upper - UpperA;
  assign idx       = idx8[LetterW-1:0];
  assign completes = is_letter && half;
  assign opens     = is_letter && !half;

  always_comb begin
    job.pair = completes;
    job.eom  = s_tlast;
    job.odd  = is_letter ^ half;
    job.p1   = opens ? idx : held;
    job.p2   = completes ? idx : LetterX;
  end

  assign push = acc && (completes || s_tlast);

  always_comb begin
    held_next = held;
    half_next = half;
    if (acc) begin
      if (s_tlast) begin
        held_next = '0;
        half_next = 1'b0;
      end else if (completes) begin
        half_next = 1'b0;
      end else if (opens) begin
        held_next = idx;
        half_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
      half <= 1'b0;
    end else begin
      held <= held_next;
      half <= half_next;
    end
  end

  `ASSERT_NEXT(a_eom_clears_half, clk, rst, acc && s_tlast, !half,
               "letter still held after end of message")

endmodule

FILE: src/hc2_queue.sv
// Short job queue between front and back end.
// Depends on hc2_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hc2_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hc2_pkg::job_t din,
  input  logic          pop,
  output hc2_pkg::job_t dout,
  output logic          empty,
  output logic          full
);
  import hc2_pkg::*;

  job_t                 slots [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr, rd_ptr;
  logic [QueueCntW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == QueueCntW'(QueueDepth));
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_no_overflow, clk, rst, push, !full || pop,
                  "job pushed into full queue")
  `ASSERT_IMPLIES(a_no_underflow, clk, rst, pop, !empty,
                  "job popped from empty queue")

endmodule

FILE: src/hc2_back.sv
// Back end: applies the matrix to queued jobs and serialises result beats.
// Depends on hc2_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hc2_back (
  input  logic          clk,
  input  logic          rst,
  input  hc2_pkg::job_t job,
  input  logic          q_empty,
  output logic          pop,
  input  hc2_pkg::mat_t mat,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [6:0]    out_letter,
  output logic          letter_valid,
  output logic          last_result,
  output logic [1:0]    status
);
  import hc2_pkg::*;

  logic    emit_pair, marker, has_out;
  status_t job_status;

  // stage E: sums of products
  logic        e_valid, e_marker, e_last;
  status_t     e_status;
  logic [10:0] e_s1, e_s2;
  // stage F: output register, one or two beats
  logic        f_valid, f_phase, f_marker, f_last;
  status_t     f_status;
  logic [6:0]  f_l1, f_l2;

  logic f_done, f_load, f_step;

  assign emit_pair = mat.ok && (job.pair || (job.eom && job.odd && !mat.decrypt));
  assign marker    = job.eom && !emit_pair;
  assign has_out   = emit_pair || marker;

  always_comb begin
    if (!mat.ok) begin
      job_status = STATUS_NOT_INVERTIBLE;
    end else if (job.odd) begin
      job_status = STATUS_ODD_LENGTH;
    end else begin
      job_status = STATUS_OK;
    end
  end

  assign f_step = f_valid && m_tready;
  assign f_done = f_step && (f_marker || f_phase);
  assign f_load = e_valid && (!f_valid || f_done);
  // jobs with nothing to show are dropped at the pop
  assign pop    = !q_empty && mat.settled && (!has_out || !e_valid || f_load);

  always_ff @(posedge clk) begin
    // a dropped job must not disturb a stage E entry still waiting for F
    if (pop && has_out) begin
      e_marker <= marker;
      e_last   <= job.eom;
      e_status <= job_status;
      e_s1     <= 11'(10'(mat.m0) * 10'(job.p1)) + 11'(10'(mat.m1) * 10'(job.p2));
      e_s2     <= 11'(10'(mat.m2) * 10'(job.p1)) + 11'(10'(mat.m3) * 10'(job.p2));
    end
    if (f_load) begin
      f_marker <= e_marker;
      f_last   <= e_last;
      f_status <= e_status;
      f_l1     <= AsciiA + 7'(mod26(e_s1));
      f_l2     <= AsciiA + 7'(mod26(e_s2));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      f_valid <= 1'b0;
      f_phase <= 1'b0;
    end else begin
      if (pop && has_out) begin
        e_valid <= 1'b1;
      end else if (f_load) begin
        e_valid <= 1'b0;
      end
      if (f_load) begin
        f_valid <= 1'b1;
        f_phase <= 1'b0;
      end else begin
        if (f_done) f_valid <= 1'b0;
        if (f_step && !f_marker && !f_phase) f_phase <= 1'b1;
      end
    end
  end

  always_comb begin
    m_tvalid     = f_valid;
    letter_valid = !f_marker;
    last_result  = f_marker || (f_phase && f_last);
    status       = f_marker ? f_status : STATUS_OK;
    if (f_marker) begin
      out_letter = '0;
    end else begin
      out_letter = f_phase ? f_l2 : f_l1;
    end
  end

  `ASSERT_IMPLIES(a_pop_settled, clk, rst, pop, mat.settled,
                  "job taken before key pipeline settled")
  `ASSERT_NEXT(a_pair_second_beat, clk, rst, f_step && !f_marker && !f_phase,
               f_valid && f_phase, "second letter of pair lost")

endmodule

FILE: src/hill_cipher_2x2.sv
// 2x2 Hill cipher mod 26, one message byte per beat in, one result per beat out.
// A byte that completes a pair or ends a message passes through the job queue,
// stage E and stage F before its first beat shows. Throughput: one byte per
// cycle while the output keeps up; a pair gives two beats, so one-letter messages
// padded with X back to back fill the job queue and stall the input. Reset (rst,
// synchronous) restores the identity key and encrypt mode; results wait after
// reset or a config write while the key pipeline refills (bytes are still taken
// into the job queue).
module hill_cipher_2x2 (
  input  logic       clk,
  input  logic       rst,
  // byte stream in
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_byte
  input  logic       s_tlast,   // end_of_message
  // result stream out
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [6:0] out_letter, [7] zero
  output logic [2:0] m_tuser,   // [0] letter_valid, [2:1] status
  output logic       m_tlast,   // last_result
  // configuration writes
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [4:0] cfg_data
);
  import hc2_pkg::*;

  mat_t       mat;
  job_t       push_job, pop_job;
  logic       push, pop, q_empty, q_full;
  logic [6:0] out_letter;
  logic       letter_valid;
  logic [1:0] status;

  // Key registers plus the det / inverse / adjugate pipeline.
  hc2_key u_key (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mat       (mat)
  );

  // Letter classification and pairing; a job per completed pair or end marker.
  hc2_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  // Decouples byte intake from result delivery.
  hc2_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_job),
    .pop   (pop),
    .dout  (pop_job),
    .empty (q_empty),
    .full  (q_full)
  );

  // Matrix multiply, mod 26 and beat serialisation.
  hc2_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job          (pop_job),
    .q_empty      (q_empty),
    .pop          (pop),
    .mat          (mat),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .out_letter   (out_letter),
    .letter_valid (letter_valid),
    .last_result  (m_tlast),
    .status       (status)
  );

  assign m_tdata = {1'b0, out_letter};
  assign m_tuser = {status, letter_valid};

endmodule
